// ===== hdl/sdpg_pkg.sv =====
// Package for the step/direction position generator.
// Holds the motion codes used by the top level and its checker, and the command codes.
// No dependencies.
package sdpg_pkg;

    localparam logic [1:0] MOTION_STOP = 2'b00;
    localparam logic [1:0] MOTION_FWD  = 2'b01;
    localparam logic [1:0] MOTION_REV  = 2'b11;
    localparam logic [1:0] MOTION_BAD  = 2'b10;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_DEST = 1'b1;

endpackage

// ===== hdl/step_dir_position_generator.sv =====
// Step/direction position generator: top level.
// Uses sdpg_pkg for motion and command codes.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_cmd, i_target
//  out     | output    | o_out_valid / i_out_stall | o_step_out, o_dir_out,
//          |           |                        | o_current_position, o_motion
//  cfg     | input     | i_cfg_we                | i_cfg_data (half period in ticks)
//
// One item per cycle sustained while the output is not stalled; an input passes through
// the input register, then the state update into the result register.
// Reset is synchronous and active low; it clears position, target, motion, levels,
// elapsed count, half period and both valid flags.
// A stalled output holds the result; the input register keeps taking one more item,
// then the input stalls until the result is transferred.
module step_dir_position_generator #(
    parameter int POSITION_WIDTH = 16,
    parameter int PERIOD_WIDTH   = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_cmd,
    input  logic signed [POSITION_WIDTH-1:0] i_target,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_step_out,
    output logic                             o_dir_out,
    output logic signed [POSITION_WIDTH-1:0] o_current_position,
    output logic signed [1:0]                o_motion,
    input  logic                             i_cfg_we,
    input  logic        [PERIOD_WIDTH-1:0]   i_cfg_data
);

    localparam int EW = PERIOD_WIDTH + 1;

    logic                      r_in_valid;
    logic                      r_cmd;
    logic [POSITION_WIDTH-1:0] r_in_target;

    logic [PERIOD_WIDTH-1:0]   r_half;
    logic [POSITION_WIDTH-1:0] r_cur, n_cur;
    logic [POSITION_WIDTH-1:0] r_tgt, n_tgt;
    logic [1:0]                r_dir, n_dir;
    logic                      r_step, n_step;
    logic                      r_dir_lvl, n_dir_lvl;
    logic [EW-1:0]             r_elapsed, n_elapsed;

    logic                      r_out_valid;
    logic                      r_o_step;
    logic                      r_o_dir;
    logic [POSITION_WIDTH-1:0] r_o_pos;
    logic [1:0]                r_o_motion;

    logic                      advance;
    logic [EW-1:0]             elapsed_a;
    logic                      do_check;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    always_comb begin
        n_tgt     = (r_cmd == sdpg_pkg::CMD_DEST) ? r_in_target : r_tgt;
        n_cur     = r_cur;
        n_dir     = r_dir;
        n_step    = r_step;
        n_dir_lvl = r_dir_lvl;
        elapsed_a = r_elapsed;
        if (r_cmd == sdpg_pkg::CMD_TICK && r_dir != sdpg_pkg::MOTION_STOP
                && r_elapsed != {EW{1'b1}}) begin
            elapsed_a = r_elapsed + EW'(1);
        end
        n_elapsed = elapsed_a;
        do_check  = (r_cmd == sdpg_pkg::CMD_TICK) || r_step;
        if (do_check) begin
            if (r_dir == sdpg_pkg::MOTION_STOP) begin
                n_elapsed = '0;
            end else if (elapsed_a > {1'b0, r_half}) begin
                if (r_cur == n_tgt) begin
                    n_dir = sdpg_pkg::MOTION_STOP;
                end else begin
                    n_dir_lvl = (r_dir != sdpg_pkg::MOTION_REV);
                    n_step    = !r_step;
                    if (r_step) begin
                        if (r_dir == sdpg_pkg::MOTION_FWD) begin
                            n_cur = r_cur + POSITION_WIDTH'(1);
                        end else begin
                            n_cur = r_cur - POSITION_WIDTH'(1);
                        end
                    end
                    n_elapsed = elapsed_a - {1'b0, r_half};
                end
            end
        end
        if (r_cmd == sdpg_pkg::CMD_DEST) begin
            if ($signed(n_tgt) > $signed(n_cur)) begin
                n_dir = sdpg_pkg::MOTION_FWD;
            end else if ($signed(n_tgt) < $signed(n_cur)) begin
                n_dir = sdpg_pkg::MOTION_REV;
            end else begin
                n_dir = sdpg_pkg::MOTION_STOP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_half      <= '0;
            r_cur       <= '0;
            r_tgt       <= '0;
            r_dir       <= sdpg_pkg::MOTION_STOP;
            r_step      <= 1'b0;
            r_dir_lvl   <= 1'b0;
            r_elapsed   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_half <= i_cfg_data;
            end
            if (!r_in_valid || advance) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_cur       <= n_cur;
                r_tgt       <= n_tgt;
                r_dir       <= n_dir;
                r_step      <= n_step;
                r_dir_lvl   <= n_dir_lvl;
                r_elapsed   <= n_elapsed;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_in_valid || advance) begin
            r_cmd       <= i_cmd;
            r_in_target <= i_target;
        end
        if (advance) begin
            r_o_step   <= n_step;
            r_o_dir    <= n_dir_lvl;
            r_o_pos    <= n_cur;
            r_o_motion <= n_dir;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_step_out         = r_o_step;
    assign o_dir_out          = r_o_dir;
    assign o_current_position = r_o_pos;
    assign o_motion           = r_o_motion;

endmodule

// ===== hdl/sdpg_checker.sv =====
// Port-level checker for the step/direction position generator, with its bind.
// Uses sdpg_pkg for motion codes; bound to step_dir_position_generator.
module sdpg_checker #(
    parameter int POSITION_WIDTH = 16
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic                      o_step_out,
    input logic                      o_dir_out,
    input logic [POSITION_WIDTH-1:0] o_current_position,
    input logic [1:0]                o_motion
);

    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_payload_stable : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_step_out) && $stable(o_dir_out)
            && $stable(o_current_position) && $stable(o_motion))
        else $error("stalled result changed");

    a_motion_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_motion != sdpg_pkg::MOTION_BAD)
        else $error("invalid motion code");

    a_no_stall_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

endmodule

bind step_dir_position_generator sdpg_checker #(
    .POSITION_WIDTH(POSITION_WIDTH)
) u_sdpg_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_in_stall         (o_in_stall),
    .o_out_valid        (o_out_valid),
    .i_out_stall        (i_out_stall),
    .o_step_out         (o_step_out),
    .o_dir_out          (o_dir_out),
    .o_current_position (o_current_position),
    .o_motion           (o_motion)
);
